// File: hdl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal core.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int CELL_W    = 17;
  localparam int T_W       = 32;
  localparam int S_DATA_W  = 192;
  localparam int M_DATA_W  = 152;
  localparam int LIMIT_W   = 15;
  localparam int VOXEL_W   = 16;

  localparam logic [T_W-1:0] T_INF = '1;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_VOXEL = 1'b1;

  localparam logic       REG_NOT_LOADED = 1'b0;
  localparam logic       REG_STEP_LIMIT = 1'b1;

  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam logic [2:0] JOB_LAST  = 3'd5;

  typedef enum logic [1:0] {
    KIND_REQUEST    = 2'd0,
    KIND_HIT        = 2'd1,
    KIND_MISS       = 2'd2,
    KIND_IDLE_REPLY = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       init_ray;
    logic       drop_ray;
    logic       div_start;
    logic       div_store;
    logic [2:0] job;
    logic       do_step;
    logic       emit;
    kind_t      emit_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic degenerate;
    logic active;
    logic hit;
    logic div_done;
    logic past_limit;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module vrt_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [31:0]   quotient
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] work;
  logic [15:0]   rem;
  logic [15:0]   dvs;
  logic [15:0]   rem_next;
  logic          qbit;
  logic [16:0]   trial;
  logic [DW+31:0] qx;

  always_comb begin
    trial = {rem, work[DW-1]};
    if (trial >= {1'b0, dvs}) begin
      qbit     = 1'b1;
      rem_next = 16'(trial - {1'b0, dvs});
    end else begin
      qbit     = 1'b0;
      rem_next = trial[15:0];
    end
  end

  // The work register shifts the dividend out at the top and the quotient in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= rem_next;
        work <= {work[DW-2:0], qbit};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(DW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign qx       = {32'b0, work};
  assign quotient = (|qx[DW+31:32]) ? '1 : qx[31:0];

endmodule

// File: hdl/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray state, configuration registers, boundary setup and the step unit.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vrt_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [vrt_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [1:0]                    m_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  vrt_pkg::cmd_t                 cmd,
  output vrt_pkg::stat_t                stat
);

  localparam int DW = FRACTION_BITS + 16;
  localparam int CW = vrt_pkg::CELL_W;
  localparam int TW = vrt_pkg::T_W;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [vrt_pkg::S_DATA_W-1:0] in_data;
  logic                         in_op;

  logic [15:0]                  empty_code;
  logic [vrt_pkg::LIMIT_W-1:0]  step_limit;

  logic                         active;
  logic [CW-1:0]                cur  [3];
  logic [CW-1:0]                prev [3];
  logic [TW-1:0]                nb   [3];
  logic [TW-1:0]                sp   [3];
  logic [2:0]                   neg;
  logic [TW-1:0]                travelled;
  logic [TW-1:0]                limit;
  logic [1:0]                   step_axis;
  logic [vrt_pkg::LIMIT_W-1:0]  cnt;

  logic [31:0]                  org  [3];
  logic [CW-1:0]                org_cell [3];
  logic [15:0]                  dir  [3];
  logic [15:0]                  mag  [3];
  logic [30:0]                  max_travel;
  logic [15:0]                  voxel;
  logic [1:0]                   job_axis;
  logic [FRACTION_BITS-1:0]     frac;
  logic [FRACTION_BITS:0]       bound_dist;
  logic [DW-1:0]                dividend;
  logic                         div_done;
  logic [31:0]                  quotient;
  logic [TW-1:0]                div_value;

  logic [1:0]                   sel;
  logic [TW:0]                  sum;
  logic [TW-1:0]                nb_next;
  logic [3:0]                   neg_ext;
  logic [vrt_pkg::M_DATA_W-1:0] out_word;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i]      = in_data[32*i +: 32];
      org_cell[i] = CW'($signed(org[i]) >>> FRACTION_BITS);
      dir[i]      = in_data[96 + 16*i +: 16];
      mag[i]      = dir[i][15] ? 16'(16'd0 - dir[i]) : dir[i];
    end
  end

  assign max_travel = in_data[174:144];
  assign voxel      = in_data[190:175];
  assign job_axis   = cmd.job[2:1];

  // Distance to the first boundary, scaled so that dividing by |d| gives t.
  always_comb begin
    frac = org[job_axis][FRACTION_BITS-1:0];
    if (!dir[job_axis][15]) begin
      bound_dist = ONE - {1'b0, frac};
    end else if (frac == '0) begin
      bound_dist = ONE;
    end else begin
      bound_dist = {1'b0, frac};
    end
    if (cmd.job[0]) begin
      dividend = {1'b1, {(DW-1){1'b0}}};
    end else begin
      dividend = {bound_dist, 15'b0};
    end
  end

  vrt_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mag[job_axis]),
    .done     (div_done),
    .quotient (quotient)
  );

  assign div_value = (mag[job_axis] == '0) ? vrt_pkg::T_INF : quotient;

  // Nearest boundary; on a tie the later axis wins.
  always_comb begin
    if (nb[0] < nb[1]) begin
      sel = (nb[0] < nb[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (nb[1] < nb[2]) ? 2'd1 : 2'd2;
    end
    sum     = {1'b0, nb[sel]} + {1'b0, sp[sel]};
    nb_next = sum[TW] ? vrt_pkg::T_INF : sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code <= 16'hFFFF;
      step_limit <= 15'd4096;
      active     <= 1'b0;
      step_axis  <= vrt_pkg::AXIS_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vrt_pkg::REG_NOT_LOADED: empty_code <= cfg_data;
          vrt_pkg::REG_STEP_LIMIT: step_limit <= cfg_data[vrt_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        in_data <= s_tdata;
        in_op   <= s_tuser;
      end
      // A start drops the old ray and may bring up a new one at once.
      if (cmd.init_ray) begin
        active <= 1'b1;
      end else if (cmd.drop_ray) begin
        active <= 1'b0;
      end
      if (cmd.init_ray) begin
        for (int i = 0; i < 3; i++) begin
          cur[i]  <= org_cell[i];
          prev[i] <= org_cell[i];
          neg[i]  <= dir[i][15];
        end
        travelled <= '0;
        limit     <= {1'b0, max_travel};
        step_axis <= vrt_pkg::AXIS_NONE;
        cnt       <= '0;
      end
      if (cmd.div_store) begin
        if (cmd.job[0]) begin
          sp[job_axis] <= div_value;
        end else begin
          nb[job_axis] <= div_value;
        end
      end
      if (cmd.do_step) begin
        for (int i = 0; i < 3; i++) begin
          prev[i] <= cur[i];
        end
        cur[sel]  <= cur[sel] + (neg[sel] ? {CW{1'b1}} : CW'(1));
        travelled <= nb[sel];
        nb[sel]   <= nb_next;
        step_axis <= sel;
        cnt       <= cnt + 1'b1;
      end
    end
  end

  assign neg_ext = {1'b0, neg};

  always_comb begin
    out_word = '0;
    out_word[150:149] = vrt_pkg::AXIS_NONE;
    if (cmd.emit_kind == vrt_pkg::KIND_REQUEST ||
        cmd.emit_kind == vrt_pkg::KIND_HIT) begin
      out_word[16:0]  = cur[0];
      out_word[33:17] = cur[1];
      out_word[50:34] = cur[2];
    end
    if (cmd.emit_kind == vrt_pkg::KIND_HIT) begin
      out_word[67:51]   = prev[0];
      out_word[84:68]   = prev[1];
      out_word[101:85]  = prev[2];
      out_word[117:102] = voxel;
      out_word[148:118] = travelled[30:0];
      out_word[150:149] = step_axis;
      out_word[151]     = (step_axis != vrt_pkg::AXIS_NONE) && neg_ext[step_axis];
    end
  end

  // Result register: a new word loads as the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tuser  <= cmd.emit_kind;
        m_tdata  <= out_word;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_start   = (in_op == vrt_pkg::OP_START);
    stat.degenerate = ((dir[0] | dir[1] | dir[2]) == '0) || (max_travel == '0);
    stat.active     = active;
    stat.hit        = (voxel != '0) && (voxel != empty_code);
    stat.div_done   = div_done;
    stat.past_limit = (travelled > limit) || (cnt >= step_limit);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

// File: hdl/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: decodes a word, runs the six setup divisions, steps and emits.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  vrt_pkg::stat_t stat,
  output vrt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_LAUNCH,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t         state;
  logic [2:0]     job;
  vrt_pkg::kind_t kind;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.job       = job;
    cmd.emit_kind = kind;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
      end
      ST_DECODE: begin
        if (stat.is_start) begin
          cmd.drop_ray = 1'b1;
          cmd.init_ray = !stat.degenerate;
        end else if (stat.active) begin
          cmd.drop_ray = stat.hit;
          cmd.do_step  = !stat.hit;
        end
      end
      ST_DIV_LAUNCH: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        cmd.div_store = stat.div_done;
      end
      ST_CHECK: begin
        cmd.drop_ray = stat.past_limit;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= '0;
      kind  <= vrt_pkg::KIND_MISS;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          priority if (stat.is_start) begin
            if (stat.degenerate) begin
              kind  <= vrt_pkg::KIND_MISS;
              state <= ST_EMIT;
            end else begin
              job   <= '0;
              state <= ST_DIV_LAUNCH;
            end
          end else if (!stat.active) begin
            kind  <= vrt_pkg::KIND_IDLE_REPLY;
            state <= ST_EMIT;
          end else if (stat.hit) begin
            kind  <= vrt_pkg::KIND_HIT;
            state <= ST_EMIT;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_DIV_LAUNCH: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (stat.div_done) begin
            if (job == vrt_pkg::JOB_LAST) begin
              kind  <= vrt_pkg::KIND_REQUEST;
              state <= ST_EMIT;
            end else begin
              job   <= job + 1'b1;
              state <= ST_DIV_LAUNCH;
            end
          end
        end
        ST_CHECK: begin
          kind  <= stat.past_limit ? vrt_pkg::KIND_MISS : vrt_pkg::KIND_REQUEST;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/voxel_ray_traversal_core.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_core
// 3D DDA voxel walker: start words set up a ray, voxel words step it.
// ----------------------------------------------------------------------------
// A stepping voxel word passes through decode, check and emit, and the next word
// is taken only once its result has loaded; a hit, a reply with no active ray
// and a degenerate start go from decode straight to emit. A start runs the six
// setup divisions one after another on the one bit-per-cycle divider that they
// share before its result loads. A stalled result holds off the next word.
// Synchronous reset clears the ray and loads 65535, 4096.
module voxel_ray_traversal_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, max_travel,
  // voxel_value, one pad bit
  input  logic [191:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_x, cell_y, cell_z, before_x, before_y, before_z, hit_id,
  // hit_distance, normal_axis, normal_positive
  output logic [151:0] m_tdata,
  // kind
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  vrt_pkg::cmd_t  cmd;
  vrt_pkg::stat_t stat;

  vrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vrt_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: tb/sv/voxel_ray_traversal_core_test.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_core_test
// Drives ray start and voxel reply words into the DDA walker, predicts each
// result word from a behavioral walker, and checks every field of the output.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_core_test;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        op;
    logic [31:0] ox, oy, oz;
    logic [15:0] dx, dy, dz;
    logic [30:0] mt;
    logic [15:0] vv;
  } ray_word_t;

  typedef struct {
    vrt_pkg::kind_t kind;
    logic [16:0] cx, cy, cz, bx, by, bz;
    logic [15:0] id;
    logic [30:0] travel;
    logic [1:0]  axis;
    logic        npos;
  } walk_result_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [151:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 0;
  logic         cfg_index = 0;
  logic [15:0]  cfg_data = '0;

  ray_word_t    word_q[$];
  ray_word_t    on_bus;
  walk_result_t trace_q[$];
  int           send_idle = 31;
  int           recv_idle = 79;
  int           errors = 0;
  int           cycles = 0;

  // Walker state kept by the testbench.
  logic [15:0]  nl_code;
  logic [14:0]  max_cells;
  logic         active;
  logic [16:0]  cur[3], prev[3];
  logic [31:0]  next_t[3], span_t[3];
  logic         neg_step[3];
  logic [31:0]  walked_t, limit_t;
  logic [1:0]   prior_axis;
  logic [14:0]  examined;

  voxel_ray_traversal_core #(.FRACTION_BITS(FRAC)) uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? vrt_pkg::T_INF : v[31:0];
  endfunction

  function automatic walk_result_t blank(vrt_pkg::kind_t k);
    walk_result_t r;
    r = '{kind: k, axis: vrt_pkg::AXIS_NONE, default: '0};
    return r;
  endfunction

  function automatic void setup_axis(int a, logic [31:0] o, logic [15:0] d);
    logic [15:0] mag;
    logic [63:0] gap;
    mag = d[15] ? -d : d;
    cur[a] = {o[31], o[31:16]};
    prev[a] = cur[a];
    neg_step[a] = d[15];
    if (mag == 0) begin
      next_t[a] = vrt_pkg::T_INF;
      span_t[a] = vrt_pkg::T_INF;
    end else begin
      if (!d[15]) gap = 64'd65536 - 64'(o[15:0]);
      else gap = (o[15:0] == 0) ? 64'd65536 : 64'(o[15:0]);
      next_t[a] = sat32((gap << 15) / 64'(mag));
      span_t[a] = sat32((64'd1 << (15 + FRAC)) / 64'(mag));
    end
  endfunction

  function automatic walk_result_t walk_word(ray_word_t w);
    walk_result_t r;
    int a;
    if (w.op == vrt_pkg::OP_START) begin
      active = 0;
      if ((w.dx | w.dy | w.dz) == 0 || w.mt == 0) return blank(vrt_pkg::KIND_MISS);
      setup_axis(0, w.ox, w.dx);
      setup_axis(1, w.oy, w.dy);
      setup_axis(2, w.oz, w.dz);
      walked_t = 0;
      limit_t = {1'b0, w.mt};
      prior_axis = vrt_pkg::AXIS_NONE;
      examined = 0;
      active = 1;
      r = blank(vrt_pkg::KIND_REQUEST);
      {r.cx, r.cy, r.cz} = {cur[0], cur[1], cur[2]};
      return r;
    end
    if (!active) return blank(vrt_pkg::KIND_IDLE_REPLY);
    if (w.vv != 0 && w.vv != nl_code) begin
      r = blank(vrt_pkg::KIND_HIT);
      {r.cx, r.cy, r.cz} = {cur[0], cur[1], cur[2]};
      {r.bx, r.by, r.bz} = {prev[0], prev[1], prev[2]};
      r.id = w.vv;
      r.travel = walked_t[30:0];
      r.axis = prior_axis;
      r.npos = (prior_axis != vrt_pkg::AXIS_NONE) && neg_step[prior_axis];
      active = 0;
      return r;
    end
    examined = examined + 1'b1;
    // Ties go to the later axis.
    if (next_t[0] < next_t[1]) a = (next_t[0] < next_t[2]) ? 0 : 2;
    else a = (next_t[1] < next_t[2]) ? 1 : 2;
    prev = cur;
    cur[a] = neg_step[a] ? cur[a] - 1'b1 : cur[a] + 1'b1;
    walked_t = next_t[a];
    next_t[a] = sat32(64'(next_t[a]) + 64'(span_t[a]));
    prior_axis = 2'(a);
    if (walked_t > limit_t || examined >= max_cells) begin
      active = 0;
      return blank(vrt_pkg::KIND_MISS);
    end
    r = blank(vrt_pkg::KIND_REQUEST);
    {r.cx, r.cy, r.cz} = {cur[0], cur[1], cur[2]};
    return r;
  endfunction

  task automatic push_start(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz,
                            logic [30:0] mt);
    word_q.insert(word_q.size(),
                  ray_word_t'{op: vrt_pkg::OP_START, ox: ox, oy: oy, oz: oz,
                              dx: dx, dy: dy, dz: dz, mt: mt, vv: 16'($urandom)});
  endtask

  task automatic push_voxel(logic [15:0] v);
    word_q.insert(word_q.size(),
                  ray_word_t'{op: vrt_pkg::OP_VOXEL, ox: $urandom, oy: $urandom,
                              oz: $urandom, dx: 16'($urandom), dy: 16'($urandom),
                              dz: 16'($urandom), mt: 31'($urandom), vv: v});
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == vrt_pkg::REG_NOT_LOADED) nl_code = value;
    else max_cells = value[14:0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || s_tvalid || trace_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_origin();
    logic [31:0] o;
    o = $urandom;
    if ($urandom_range(9) < 7) o[31:16] = 16'($signed($urandom_range(16)) - 8);
    return o;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] empty_value();
    return $urandom_range(1) ? 16'h0000 : nl_code;
  endfunction

  // One ray: a start, some empty replies, maybe a hit, maybe a stray reply.
  task automatic push_random_ray(inout int count);
    logic [30:0] mt;
    int n;
    case ($urandom_range(19))
      0: mt = 0;
      1, 2: mt = 31'($urandom);
      default: mt = 31'($urandom_range(1, 24 << FRAC));
    endcase
    push_start(rand_origin(), rand_origin(), rand_origin(),
               rand_dir(), rand_dir(), rand_dir(), mt);
    n = $urandom_range(12);
    count += n + 1;
    repeat (n) push_voxel(empty_value());
    if ($urandom_range(2) != 0) begin
      push_voxel(16'($urandom));
      count++;
    end
    if ($urandom_range(7) == 0) begin
      push_voxel(16'($urandom));
      count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) trace_q.insert(trace_q.size(), walk_word(on_bus));
      if (!s_tvalid || s_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          on_bus = word_q.pop_front();
          s_tvalid <= 1;
          s_tuser <= on_bus.op;
          s_tdata <= {1'b0, on_bus.vv, on_bus.mt, on_bus.dz, on_bus.dy, on_bus.dx,
                      on_bus.oz, on_bus.oy, on_bus.ox};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    walk_result_t e;
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) begin
      if (trace_q.size() == 0) begin
        $error("unexpected result word, kind %0d", m_tuser);
        errors++;
      end else begin
        e = trace_q.pop_front();
        if (m_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_tuser); errors++;
        end
        if (m_tdata[16:0] !== e.cx) begin
          $error("cell_x: expected %h, got %h", e.cx, m_tdata[16:0]); errors++;
        end
        if (m_tdata[33:17] !== e.cy) begin
          $error("cell_y: expected %h, got %h", e.cy, m_tdata[33:17]); errors++;
        end
        if (m_tdata[50:34] !== e.cz) begin
          $error("cell_z: expected %h, got %h", e.cz, m_tdata[50:34]); errors++;
        end
        if (m_tdata[67:51] !== e.bx) begin
          $error("before_x: expected %h, got %h", e.bx, m_tdata[67:51]); errors++;
        end
        if (m_tdata[84:68] !== e.by) begin
          $error("before_y: expected %h, got %h", e.by, m_tdata[84:68]); errors++;
        end
        if (m_tdata[101:85] !== e.bz) begin
          $error("before_z: expected %h, got %h", e.bz, m_tdata[101:85]); errors++;
        end
        if (m_tdata[117:102] !== e.id) begin
          $error("hit_id: expected %h, got %h", e.id, m_tdata[117:102]); errors++;
        end
        if (m_tdata[148:118] !== e.travel) begin
          $error("hit_distance: expected %h, got %h", e.travel, m_tdata[148:118]);
          errors++;
        end
        if (m_tdata[150:149] !== e.axis) begin
          $error("normal_axis: expected %0d, got %0d", e.axis, m_tdata[150:149]);
          errors++;
        end
        if (m_tdata[151] !== e.npos) begin
          $error("normal_positive: expected %0d, got %0d", e.npos, m_tdata[151]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("voxel_ray_traversal_core test failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] nl_set[4];
    logic [15:0] limit_set[4];
    int count;
    nl_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
    nl_set[2] = 16'($urandom);
    nl_set[3] = 16'($urandom);
    // The last step limit sets the unused top bit and leaves zero behind.
    limit_set = '{16'd8, 16'd1, 16'd16384, 16'h8000};
    nl_code = 16'hFFFF;
    max_cells = 15'd4096;
    active = 0;
    prior_axis = vrt_pkg::AXIS_NONE;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed words at reset settings.
    push_voxel(16'h1234);
    push_start(32'h0001_8000, 32'h0002_0000, 32'hFFFF_4000, 16'h0000, 16'h0000,
               16'h0000, 31'd100);
    push_start(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 31'd0);
    push_start(32'h0001_8000, 32'h0002_0000, 32'hFFFF_4000, 16'h5A82, 16'h8000,
               16'h2000, 31'h7FFF_FFFF);
    push_voxel(16'h0000);
    push_voxel(16'hFFFF);
    push_voxel(16'h0000);
    push_voxel(16'hFFFE);
    push_voxel(16'h0001);
    push_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h7FFF, 16'h8001,
               16'hC000, 31'h0001_0000);
    push_voxel(16'h0000);
    // A new start drops the ray still in flight.
    push_start(32'h8000_0000, 32'h7FFF_0001, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF,
               16'h0001, 31'h7FFF_FFFF);
    push_voxel(16'h0000);
    push_voxel(16'hFFFF);
    push_voxel(16'h8000);
    // A tiny x direction puts the first boundary past the limit, so the first step misses.
    push_start(32'h0000_0000, 32'h0, 32'h0, 16'h0001, 16'h0, 16'h0, 31'h7FFF_FFFF);
    repeat (6) push_voxel(16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_reg(vrt_pkg::REG_NOT_LOADED, nl_set[ph]);
      write_reg(vrt_pkg::REG_STEP_LIMIT, limit_set[ph]);
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 79 : 0;
      recv_idle = (ph == 0) ? 79 : (ph == 1) ? 31 : 0;
      count = 0;
      while (count < 225) push_random_ray(count);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("voxel_ray_traversal_core test passed");
    else $display("voxel_ray_traversal_core test failed");
    $finish;
  end

endmodule
